>>> sv/tmr_pkg.sv
// Shared types and constants for the tangent mirror block.
`timescale 1ns / 1ps
package tmr_pkg;

  localparam int unsigned AW  = 33;        // |D| component magnitude
  localparam int unsigned TW  = 32;        // tangent component
  localparam int unsigned PW  = 66;        // products and squares
  localparam int unsigned DTW = 67;        // signed dot product
  localparam int unsigned HW  = 33;        // half of |D.t| for split multiply
  localparam int unsigned NW  = 103;       // dividend
  localparam int unsigned DW  = 67;        // divisor 2*(D.D)
  localparam int unsigned QW  = 36;        // quotient bits (|q| < 2^35)
  localparam int unsigned VW  = 38;        // final signed sum
  localparam int unsigned SDW = TW + 2;    // divider sideband: zero, sign, t
  localparam int unsigned QDEPTH_DEF = 2;
  localparam int unsigned LATENCY = QW + 7;

  typedef struct packed {
    logic                    flat;
    logic [2:0]              dneg;
    logic [2:0][AW-1:0]      ad;
    logic [2:0][TW-1:0]      t;
  } item_t;

endpackage

>>> sv/tangent_mirror_reflection.sv
// Top level of the tangent mirror block.
`timescale 1ns / 1ps
// Mirrors a tangent about the line through two points: R = 2(D.t)D/(D.D) - t,
// rounded half away from zero, saturated to 32 bits, with z forced to zero on
// 2D tracks. A word is taken on any cycle with start high and busy low, one per
// cycle sustained; each result appears with out_valid for one cycle once its
// word has passed the front register, the queue, four arithmetic stages, the
// 36-stage divider pipeline and the output register. The receiver cannot
// stall, so the back end drains the queue every cycle and busy stays low in
// normal use.
module tangent_mirror_reflection import tmr_pkg::*; #(
  parameter int unsigned QDEPTH = QDEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic         in_req_type,
  input  logic [31:0]  in_src_x,
  input  logic [31:0]  in_src_y,
  input  logic [31:0]  in_src_z,
  input  logic [31:0]  in_tan_x,
  input  logic [31:0]  in_tan_y,
  input  logic [31:0]  in_tan_z,
  input  logic [31:0]  in_dst_x,
  input  logic [31:0]  in_dst_y,
  input  logic [31:0]  in_dst_z,
  output logic         out_valid,
  output logic [31:0]  out_refl_x,
  output logic [31:0]  out_refl_y,
  output logic [31:0]  out_refl_z,
  output logic         out_degenerate,
  output logic         out_saturated
);

  logic  fv, qv;
  item_t fitem, qitem;

  tmr_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_src_x, .in_src_y, .in_src_z,
    .in_tan_x, .in_tan_y, .in_tan_z, .in_dst_x, .in_dst_y, .in_dst_z,
    .fv_o   (fv),
    .item_o (fitem)
  );

  tmr_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n,
    .push      (fv),
    .push_data (fitem),
    .busy_o    (busy),
    .pop_valid (qv),
    .pop_data  (qitem)
  );

  tmr_back u_back (
    .clk, .rst_n,
    .in_v (qv),
    .item (qitem),
    .out_valid, .out_refl_x, .out_refl_y, .out_refl_z,
    .out_degenerate, .out_saturated
  );

endmodule

>>> sv/tmr_front.sv
// Front end: accept a word, form D = dst - src and split it into sign and magnitude.
`timescale 1ns / 1ps
module tmr_front import tmr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  logic          in_req_type,
  input  logic [31:0]   in_src_x,
  input  logic [31:0]   in_src_y,
  input  logic [31:0]   in_src_z,
  input  logic [31:0]   in_tan_x,
  input  logic [31:0]   in_tan_y,
  input  logic [31:0]   in_tan_z,
  input  logic [31:0]   in_dst_x,
  input  logic [31:0]   in_dst_y,
  input  logic [31:0]   in_dst_z,
  output logic          fv_o,
  output item_t         item_o
);

  logic        v_r;
  item_t       item_r, item_nxt;
  logic [31:0] src [3];
  logic [31:0] dst [3];
  logic [31:0] tan [3];
  logic [AW-1:0] d [3];

  assign src[0] = in_src_x; assign src[1] = in_src_y; assign src[2] = in_src_z;
  assign dst[0] = in_dst_x; assign dst[1] = in_dst_y; assign dst[2] = in_dst_z;
  assign tan[0] = in_tan_x; assign tan[1] = in_tan_y; assign tan[2] = in_tan_z;

  always_comb begin
    item_nxt.flat = in_req_type;
    for (int k = 0; k < 3; k++) begin
      d[k] = {dst[k][31], dst[k]} - {src[k][31], src[k]};
      item_nxt.t[k] = tan[k];
      if (k == 2 && in_req_type) begin
        // drop z on a 2D track
        d[k] = '0;
        item_nxt.t[k] = '0;
      end
      item_nxt.dneg[k] = d[k][AW-1];
      item_nxt.ad[k]   = d[k][AW-1] ? (~d[k] + AW'(1)) : d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= start && !busy;
    end
    if (start && !busy) begin
      item_r <= item_nxt;
    end
  end

  assign fv_o   = v_r;
  assign item_o = item_r;

endmodule

>>> sv/tmr_queue.sv
// Short queue of classified words between front and back.
`timescale 1ns / 1ps
module tmr_queue import tmr_pkg::*; #(
  parameter int unsigned DEPTH = QDEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  item_t  push_data,
  output logic   busy_o,
  output logic   pop_valid,
  output item_t  pop_data
);

  localparam int unsigned PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1) + 1;

  item_t          mem [DEPTH];
  logic [PTW-1:0] wr_r, rd_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem[rd_r];
  assign cnt_nxt   = cnt_r + CW'(push) - CW'(pop_valid);
  // hold off the source when the word in the front stage could not fit
  assign busy_o    = (cnt_nxt >= CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= (wr_r == PTW'(DEPTH - 1)) ? '0 : wr_r + PTW'(1);
      end
      if (pop_valid) begin
        rd_r <= (rd_r == PTW'(DEPTH - 1)) ? '0 : rd_r + PTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
  end

endmodule

>>> sv/tmr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tmr_div import tmr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_v,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SDW-1:0] side_in,
  output logic           out_v,
  output logic [QW-1:0]  quo,
  output logic [SDW-1:0] side_out
);

  logic           v_r    [QW];
  logic [NW-1:0]  rem_r  [QW];
  logic [DW-1:0]  den_r  [QW];
  logic [QW-1:0]  quo_r  [QW];
  logic [SDW-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic           v_i;
    logic [NW-1:0]  rem_i, dsh;
    logic [DW-1:0]  den_i;
    logic [QW-1:0]  quo_i;
    logic [SDW-1:0] side_i;
    logic           ge;

    if (s == 0) begin : g_first
      assign v_i = in_v;  assign rem_i = num;  assign den_i = den;
      assign quo_i = '0;  assign side_i = side_in;
    end else begin : g_next
      assign v_i = v_r[s-1];  assign rem_i = rem_r[s-1];  assign den_i = den_r[s-1];
      assign quo_i = quo_r[s-1];  assign side_i = side_r[s-1];
    end

    assign dsh = NW'(den_i) << (QW - 1 - s);
    assign ge  = (rem_i >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_i;
      end
      rem_r[s]  <= ge ? (rem_i - dsh) : rem_i;
      den_r[s]  <= den_i;
      quo_r[s]  <= {quo_i[QW-2:0], ge};
      side_r[s] <= side_i;
    end
  end

  assign out_v    = v_r[QW-1];
  assign quo      = quo_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

>>> sv/tmr_back.sv
// Back end: dot products, scaled numerators, division and saturation.
`timescale 1ns / 1ps
module tmr_back import tmr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_v,
  input  item_t        item,
  output logic         out_valid,
  output logic [31:0]  out_refl_x,
  output logic [31:0]  out_refl_y,
  output logic [31:0]  out_refl_z,
  output logic         out_degenerate,
  output logic         out_saturated
);

  // stage 1: per-lane products
  logic               v1_r;
  logic [PW-1:0]      p1_r  [3];
  logic [PW-1:0]      sq1_r [3];
  logic [2:0]         sg1_r;
  item_t              it1_r;
  logic [TW-1:0]      at [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      at[k] = item.t[k][TW-1] ? (~item.t[k] + TW'(1)) : item.t[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_v;
    for (int k = 0; k < 3; k++) begin
      p1_r[k]  <= item.ad[k] * {1'b0, at[k]};
      sq1_r[k] <= item.ad[k] * item.ad[k];
      sg1_r[k] <= item.dneg[k] ^ item.t[k][TW-1];
    end
    it1_r <= item;
  end

  // stage 2: D.t and D.D
  logic                  v2_r;
  logic [PW-1:0]         dtm2_r, dd2_r;
  logic                  dtn2_r;
  item_t                 it2_r;
  logic signed [DTW-1:0] dt;
  logic signed [DTW-1:0] ps [3];
  logic [DTW-1:0]        dtm;

  always_comb begin
    dt = '0;
    for (int k = 0; k < 3; k++) begin
      ps[k] = sg1_r[k] ? -$signed({1'b0, p1_r[k]}) : $signed({1'b0, p1_r[k]});
      dt    = dt + ps[k];
    end
    dtm = dt[DTW-1] ? DTW'(-dt) : DTW'(dt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    dtm2_r <= dtm[PW-1:0];
    dtn2_r <= dt[DTW-1];
    dd2_r  <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    it2_r  <= it1_r;
  end

  // stage 3: |D.t| * |D_k| split into two partial products
  logic          v3_r;
  logic [PW-1:0] pl3_r [3];
  logic [PW-1:0] ph3_r [3];
  logic [PW-1:0] dd3_r;
  logic          dtn3_r;
  item_t         it3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    for (int k = 0; k < 3; k++) begin
      pl3_r[k] <= dtm2_r[HW-1:0] * it2_r.ad[k];
      ph3_r[k] <= dtm2_r[PW-1:HW] * it2_r.ad[k];
    end
    dd3_r  <= dd2_r;
    dtn3_r <= dtn2_r;
    it3_r  <= it2_r;
  end

  // stage 4: numerator 4|D.t||D_k| + D.D, divisor 2 D.D
  logic           v4_r;
  logic [NW-1:0]  num4_r [3];
  logic [DW-1:0]  den4_r;
  logic [SDW-1:0] sd4_r  [3];
  logic           zero;

  assign zero = (dd3_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
    for (int k = 0; k < 3; k++) begin
      num4_r[k] <= (NW'(ph3_r[k]) << (HW + 2)) + (NW'(pl3_r[k]) << 2) + NW'(dd3_r);
      sd4_r[k]  <= {zero, dtn3_r ^ it3_r.dneg[k], it3_r.t[k]};
    end
    den4_r <= {dd3_r, 1'b0};
  end

  logic           dv [3];
  logic [QW-1:0]  q  [3];
  logic [SDW-1:0] sd [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tmr_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_v     (v4_r),
      .num      (num4_r[k]),
      .den      (den4_r),
      .side_in  (sd4_r[k]),
      .out_v    (dv[k]),
      .quo      (q[k]),
      .side_out (sd[k])
    );
  end

  // final: apply sign, subtract t, clamp
  logic                 ov_r;
  logic [31:0]          r_r [3];
  logic                 deg_r, sat_r;
  logic signed [VW-1:0] qs [3];
  logic signed [VW-1:0] v  [3];
  logic [31:0]          rc [3];
  logic [2:0]           sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qs[k] = sd[k][SDW-1] ? '0 : $signed({2'b0, q[k]});
      if (sd[k][SDW-2]) qs[k] = -qs[k];
      v[k]   = qs[k] - VW'($signed(sd[k][TW-1:0]));
      sat[k] = 1'b0;
      rc[k]  = v[k][31:0];
      if (v[k] > $signed(VW'(32'sh7FFF_FFFF))) begin
        rc[k] = 32'h7FFF_FFFF; sat[k] = 1'b1;
      end else if (v[k] < $signed(VW'(-64'sd2147483648))) begin
        rc[k] = 32'h8000_0000; sat[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= dv[0];
    for (int k = 0; k < 3; k++) r_r[k] <= rc[k];
    deg_r <= sd[0][SDW-1];
    sat_r <= |sat;
  end

  assign out_valid      = ov_r;
  assign out_refl_x     = r_r[0];
  assign out_refl_y     = r_r[1];
  assign out_refl_z     = r_r[2];
  assign out_degenerate = deg_r;
  assign out_saturated  = sat_r;

endmodule

>>> sv/tmr_checker.sv
// Port-level checks for the tangent mirror block, bound to the top level.
`timescale 1ns / 1ps
module tmr_checker import tmr_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // every accepted word comes out at fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("result missing at fixed latency");

  // nothing comes out that was not started
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    ##LATENCY out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a started word");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // back end drains every cycle, so the queue never fills
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised");

endmodule

bind tangent_mirror_reflection tmr_checker u_tmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

>>> verif/tb_tangent_mirror_reflection.sv
// Self-checking testbench for the tangent mirror block.
`timescale 1ns / 1ps
module tb_tangent_mirror_reflection;
  import tmr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] rx, ry, rz;
    logic        degen, sat;
  } refl_t;

  logic        clk, rst_n, start, busy;
  logic        in_req_type;
  logic [31:0] in_src_x, in_src_y, in_src_z, in_tan_x, in_tan_y, in_tan_z;
  logic [31:0] in_dst_x, in_dst_y, in_dst_z;
  logic        out_valid, out_degenerate, out_saturated;
  logic [31:0] out_refl_x, out_refl_y, out_refl_z;

  refl_t       refl_queue[$];
  int          errors = 0;
  int          cycles = 0;
  bit          no_idle = 0;

  tangent_mirror_reflection u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Exact mirror of t about D, rounded half away from zero, then clamped.
  function automatic refl_t mirror_tangent(logic flat, logic [31:0] s[3],
                                           logic [31:0] t[3], logic [31:0] p[3]);
    refl_t r;
    logic signed [33:0]  d[3];
    logic signed [33:0]  tv[3];
    logic signed [127:0] dot, dd, num, q, v;
    int n;
    n = flat ? 2 : 3;
    dot = '0;
    dd = '0;
    for (int k = 0; k < 3; k++) begin
      if (k < n) begin
        d[k] = $signed(p[k]) - $signed(s[k]);
        tv[k] = $signed(t[k]);
      end else begin
        d[k] = '0;
        tv[k] = '0;
      end
      dot += d[k] * tv[k];
      dd += d[k] * d[k];
    end
    r.degen = (dd == 0);
    r.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      v = '0;
      if (k < n) begin
        q = '0;
        if (dd != 0) begin
          num = 2 * dot * d[k];
          if (num < 0) q = -((-2 * num + dd) / (2 * dd));
          else q = (2 * num + dd) / (2 * dd);
        end
        v = q - tv[k];
        if (v > 128'sd2147483647) begin
          v = 128'sd2147483647;
          r.sat = 1'b1;
        end
        if (v < -128'sd2147483648) begin
          v = -128'sd2147483648;
          r.sat = 1'b1;
        end
      end
      case (k)
        0: r.rx = v[31:0];
        1: r.ry = v[31:0];
        default: r.rz = v[31:0];
      endcase
    end
    return r;
  endfunction

  task automatic send_track(logic flat, logic [31:0] s[3], logic [31:0] t[3],
                            logic [31:0] p[3]);
    while (!no_idle && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= flat;
    {in_src_x, in_src_y, in_src_z} <= {s[0], s[1], s[2]};
    {in_tan_x, in_tan_y, in_tan_z} <= {t[0], t[1], t[2]};
    {in_dst_x, in_dst_y, in_dst_z} <= {p[0], p[1], p[2]};
    @(posedge clk);
    while (busy) @(posedge clk);
    refl_queue.push_back(mirror_tangent(flat, s, t, p));
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(2) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      2: return $signed($urandom_range(2000)) - 1000;
      default: return {{12{$urandom_range(1) == 1}}, 20'($urandom())};
    endcase
  endfunction

  always @(posedge clk) begin
    refl_t e;
    if (rst_n && out_valid) begin
      if (refl_queue.size() == 0) begin
        $display("%0t: unexpected word", $time);
        errors++;
      end else begin
        e = refl_queue.pop_front();
        if (out_refl_x !== e.rx || out_refl_y !== e.ry || out_refl_z !== e.rz ||
            out_degenerate !== e.degen || out_saturated !== e.sat) begin
          $display("%0t: expected %h %h %h d%b s%b actual %h %h %h d%b s%b", $time,
                   e.rx, e.ry, e.rz, e.degen, e.sat, out_refl_x, out_refl_y,
                   out_refl_z, out_degenerate, out_saturated);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    logic [31:0] s[3], t[3], p[3];
    // Coincident points, extreme tangents: -t and clamp of -(-2^31).
    s = '{32'h10, 32'h20, 32'h30};
    t = '{32'h8000_0000, 32'h7fff_ffff, 32'h1_0000};
    send_track(1'b0, s, t, s);
    send_track(1'b1, s, t, s);
    // Extreme points, widest D.
    s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_track(1'b0, s, t, p);
    send_track(1'b1, s, t, p);
    send_track(1'b0, p, t, s);
    t = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send_track(1'b0, s, t, p);
    t = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_track(1'b0, p, t, s);
    // z differing only: degenerate on a 2D track, not on a 3D one.
    p = '{32'h8000_0000, 32'h8000_0000, 32'h1234};
    send_track(1'b1, s, t, p);
    send_track(1'b0, s, t, p);
    // Small cases, axis-aligned and oblique.
    s = '{0, 0, 0};
    p = '{32'h1_0000, 0, 0};
    t = '{32'h1_0000, 32'h1_0000, 32'hffff_0000};
    send_track(1'b0, s, t, p);
    p = '{2, 2, 0};
    t = '{1, 0, 0};
    send_track(1'b1, s, t, p);
    p = '{3, 1, 1};
    send_track(1'b0, s, t, p);
    t = '{32'hffff_ffff, 0, 5};
    send_track(1'b0, s, t, p);
  endtask

  task automatic test_random(int count);
    logic [31:0] s[3], t[3], p[3];
    int mode;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 2) && (i < count / 2 + 300);
      mode = $urandom_range(3);
      for (int k = 0; k < 3; k++) begin
        s[k] = rand_coord(mode);
        t[k] = rand_coord($urandom_range(3));
        p[k] = rand_coord(mode);
      end
      if ($urandom_range(19) == 0) p = s;
      send_track(1'($urandom_range(1)), s, t, p);
    end
    no_idle = 0;
  endtask

  initial begin
    start = 1'b0;
    rst_n = 1'b0;
    in_req_type = 1'b0;
    {in_src_x, in_src_y, in_src_z, in_tan_x, in_tan_y, in_tan_z} = '0;
    {in_dst_x, in_dst_y, in_dst_z} = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1750);
    start <= 1'b0;
    while (refl_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
